### rtl/size_class_free_list_allocator_unit_defines.svh
// Assertion macros used by the allocator controller.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
// Checks a property at each rising clock edge outside reset.
`define SCFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define SCFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`endif

### rtl/scfa_pkg.sv
// Package with the constants, codes and types of the size class allocator.
package scfa_pkg;

  localparam int ArenaBytes  = 65536;
  localparam int Grain       = 8;
  localparam int GrainLog    = $clog2(Grain);
  localparam int SmallMax    = 128;
  localparam int NumClasses  = 16;
  localparam int RefillCount = 20;
  localparam int NGran       = ArenaBytes / Grain;
  localparam int GranW       = 14;
  localparam int LinkAw      = $clog2(NGran);
  localparam int ClsW        = $clog2(NumClasses);

  localparam logic [GranW-1:0] Nil = GranW'(NGran);

  // Command codes.
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_LARGE = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FREE, S_POP, S_POP_WB, S_CHUNK, S_REFILL,
    S_DIV, S_SCAN, S_SCAN_WB, S_CARVE, S_ALLOC_OK, S_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DECODE, OP_PUSH_OLD, OP_POP_RD, OP_POP_WB,
    OP_TAKE_ALL, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_PUSH_LEFT,
    OP_REFILL, OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_NEXT, OP_SCAN_WB,
    OP_CARVE, OP_FAIL, OP_ALLOC_OK
  } dp_op_e;

  // Which list head the datapath reads and writes this cycle.
  typedef enum logic [1:0] {
    HS_CLS, HS_SCAN, HS_FREE, HS_LEFT
  } head_sel_e;

  typedef struct packed {
    dp_op_e    op;
    head_sel_e hsel;
  } dp_cmd_t;

  typedef struct packed {
    logic dec_alloc;
    logic dec_free;
    logic head_ok;
    logic left_ge_need;
    logic left_ge_sz;
    logic left_nz;
    logic get_fits;
    logic rem_ge_sz;
    logic scan_last;
    logic cnt_gt1;
    logic carve_last;
    logic k_lt_cnt;
    logic realloc_free;
  } dp_sts_t;

endpackage

### rtl/scfa_ram.sv
// Generic single write port RAM with a registered read port.
module scfa_ram #(
  parameter int Width = 14,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/scfa_datapath.sv
// Datapath of the allocator: list heads, pool registers, link store and work registers.
module scfa_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scfa_pkg::dp_cmd_t    cmd_i,
  input  logic [1:0]           cmd_field_i,
  input  logic [15:0]          size_i,
  input  logic [15:0]          block_addr_i,
  input  logic [15:0]          new_size_i,
  output scfa_pkg::dp_sts_t    sts_o,
  output logic [15:0]          result_addr_o,
  output logic [1:0]           status_o,
  output logic [7:0]           copy_bytes_o
);

  import scfa_pkg::*;

  function automatic logic [16:0] align_up(logic [15:0] n);
    return ({1'b0, n} + 17'(Grain - 1)) & ~17'(Grain - 1);
  endfunction

  function automatic logic [ClsW-1:0] class_of(logic [16:0] n);
    return ClsW'((n - 17'd1) >> GrainLog);
  endfunction

  // Control state.
  logic [GranW-1:0] head_q [NumClasses];
  logic [GranW-1:0] head_d [NumClasses];
  logic [16:0] pool_start_q, pool_start_d, pool_end_q, pool_end_d;
  logic [16:0] arena_top_q, arena_top_d, heap_total_q, heap_total_d;

  // Request and work registers.
  logic [1:0]       op_q, op_d;
  logic [15:0]      size_q, size_d, addr_q, addr_d, nsz_q, nsz_d;
  logic [ClsW-1:0]  cls_q, cls_d, scan_q, scan_d;
  logic [7:0]       sz_q, sz_d;
  logic [11:0]      need_q, need_d;
  logic [4:0]       cnt_q, cnt_d, k_q, k_d;
  logic [16:0]      rem_q, rem_d;
  logic [GranW-1:0] gk_q, gk_d;
  logic [15:0]      res_q, res_d;
  logic [1:0]       st_q, st_d;
  logic [7:0]       copy_q, copy_d;

  // Link store port.
  logic              ram_we;
  logic [LinkAw-1:0] ram_waddr, ram_raddr;
  logic [GranW-1:0]  ram_wdata, ram_rdata;

  // Derived values.
  logic [15:0]      alloc_n;
  logic [ClsW-1:0]  alloc_cls, hidx;
  logic [7:0]       alloc_sz;
  logic [16:0]      left, heap_rnd, get;
  logic [4:0]       step;
  logic [GranW-1:0] head_rd, g_first;
  logic             size_ok, nsz_ok;
  logic             dec_alloc, dec_free, dec_same;
  logic [1:0]       dec_st;

  assign alloc_n   = (op_q == CMD_REALLOC) ? nsz_q : size_q;
  assign alloc_cls = class_of({1'b0, alloc_n});
  assign alloc_sz  = 8'(({4'b0, alloc_cls} + 8'd1) << GrainLog);
  assign left      = pool_end_q - pool_start_q;
  assign heap_rnd  = ((heap_total_q >> 4) + 17'(Grain - 1)) & ~17'(Grain - 1);
  assign get       = 17'({need_q, 1'b0}) + heap_rnd;
  assign step      = 5'(sz_q >> GrainLog);
  assign g_first   = GranW'(pool_start_q >> GrainLog) + GranW'(step);
  assign size_ok   = (size_q != 16'd0) && (size_q <= 16'(SmallMax));
  assign nsz_ok    = (nsz_q != 16'd0) && (nsz_q <= 16'(SmallMax));

  // Head selection: one list head is read and written per cycle.
  always_comb begin
    case (cmd_i.hsel)
      HS_CLS:  hidx = cls_q;
      HS_SCAN: hidx = scan_q;
      HS_FREE: hidx = class_of({1'b0, size_q});
      HS_LEFT: hidx = class_of(left);
      default: hidx = cls_q;
    endcase
  end
  assign head_rd = head_q[hidx];

  // Request decode.
  always_comb begin
    dec_alloc = 1'b0;
    dec_free  = 1'b0;
    dec_same  = 1'b0;
    dec_st    = ST_OK;
    case (op_q)
      CMD_ALLOC: begin
        if (size_q == 16'd0) dec_st = ST_ZERO;
        else if (!size_ok) dec_st = ST_LARGE;
        else dec_alloc = 1'b1;
      end
      CMD_FREE: begin
        if (size_q == 16'd0) dec_st = ST_ZERO;
        else if (!size_ok) dec_st = ST_LARGE;
        else dec_free = 1'b1;
      end
      CMD_REALLOC: begin
        if ((size_q > 16'(SmallMax)) && (nsz_q > 16'(SmallMax))) dec_st = ST_LARGE;
        else if (align_up(size_q) == align_up(nsz_q)) dec_same = 1'b1;
        else if (nsz_q == 16'd0) dec_st = ST_ZERO;
        else if (!nsz_ok) dec_st = ST_LARGE;
        else dec_alloc = 1'b1;
      end
      default: dec_st = ST_OK;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    sts_o.dec_alloc    = dec_alloc;
    sts_o.dec_free     = dec_free;
    sts_o.head_ok      = head_rd < GranW'(NGran);
    sts_o.left_ge_need = left >= 17'(need_q);
    sts_o.left_ge_sz   = left >= 17'(sz_q);
    sts_o.left_nz      = left != 17'd0;
    sts_o.get_fits     = (arena_top_q <= 17'(ArenaBytes)) &&
                         (get <= 17'(ArenaBytes) - arena_top_q);
    sts_o.rem_ge_sz    = rem_q >= 17'(sz_q);
    sts_o.scan_last    = scan_q == ClsW'(NumClasses - 1);
    sts_o.cnt_gt1      = cnt_q > 5'd1;
    sts_o.carve_last   = (k_q + 5'd1) == cnt_q;
    sts_o.k_lt_cnt     = k_q < cnt_q;
    sts_o.realloc_free = (op_q == CMD_REALLOC) && size_ok;
  end

  // Operation execution.
  always_comb begin
    head_d       = head_q;
    pool_start_d = pool_start_q;
    pool_end_d   = pool_end_q;
    arena_top_d  = arena_top_q;
    heap_total_d = heap_total_q;
    op_d   = op_q;
    size_d = size_q;
    addr_d = addr_q;
    nsz_d  = nsz_q;
    cls_d  = cls_q;
    scan_d = scan_q;
    sz_d   = sz_q;
    need_d = need_q;
    cnt_d  = cnt_q;
    k_d    = k_q;
    rem_d  = rem_q;
    gk_d   = gk_q;
    res_d  = res_q;
    st_d   = st_q;
    copy_d = copy_q;
    ram_we    = 1'b0;
    ram_waddr = LinkAw'(gk_q);
    ram_wdata = head_rd;
    ram_raddr = LinkAw'(head_rd);
    case (cmd_i.op)
      OP_LOAD: begin
        op_d   = cmd_field_i;
        size_d = size_i;
        addr_d = block_addr_i;
        nsz_d  = new_size_i;
      end
      OP_DECODE: begin
        st_d   = dec_st;
        res_d  = dec_same ? addr_q : 16'd0;
        copy_d = 8'd0;
        cls_d  = alloc_cls;
        sz_d   = alloc_sz;
        need_d = 12'(12'(alloc_sz) * 12'(RefillCount));
        cnt_d  = 5'(RefillCount);
      end
      OP_PUSH_OLD: begin
        ram_we       = 1'b1;
        ram_waddr    = LinkAw'(addr_q >> GrainLog);
        head_d[hidx] = GranW'(addr_q >> GrainLog);
      end
      OP_POP_RD, OP_SCAN_RD: begin
        gk_d = head_rd;
      end
      OP_POP_WB: begin
        head_d[hidx] = ram_rdata;
        res_d        = 16'({gk_q, {GrainLog{1'b0}}});
      end
      OP_TAKE_ALL: begin
        pool_start_d = pool_start_q + 17'(need_q);
        gk_d         = g_first;
        k_d          = 5'd1;
        res_d        = pool_start_q[15:0];
      end
      OP_DIV_INIT: begin
        rem_d = left;
        cnt_d = 5'd0;
      end
      OP_DIV_STEP: begin
        rem_d = rem_q - 17'(sz_q);
        cnt_d = cnt_q + 5'd1;
      end
      OP_DIV_END: begin
        pool_start_d = pool_end_q - rem_q;
        gk_d         = g_first;
        k_d          = 5'd1;
        res_d        = pool_start_q[15:0];
      end
      OP_PUSH_LEFT: begin
        ram_we       = 1'b1;
        ram_waddr    = LinkAw'(pool_start_q >> GrainLog);
        head_d[hidx] = GranW'(pool_start_q >> GrainLog);
        pool_start_d = pool_end_q;
      end
      OP_REFILL: begin
        pool_start_d = arena_top_q;
        pool_end_d   = arena_top_q + get;
        arena_top_d  = arena_top_q + get;
        heap_total_d = heap_total_q + get;
      end
      OP_SCAN_INIT: begin
        scan_d = cls_q;
      end
      OP_SCAN_NEXT: begin
        scan_d = scan_q + ClsW'(1);
      end
      OP_SCAN_WB: begin
        head_d[hidx] = ram_rdata;
        pool_start_d = 17'({gk_q, {GrainLog{1'b0}}});
        pool_end_d   = 17'({gk_q, {GrainLog{1'b0}}}) +
                       17'({({1'b0, scan_q} + (ClsW+1)'(1)), {GrainLog{1'b0}}});
      end
      OP_CARVE: begin
        if (k_q == 5'd1) begin
          head_d[hidx] = gk_q;
        end
        ram_we    = 1'b1;
        ram_waddr = LinkAw'(gk_q);
        ram_wdata = sts_o.carve_last ? Nil : (gk_q + GranW'(step));
        gk_d      = gk_q + GranW'(step);
        k_d       = k_q + 5'd1;
      end
      OP_FAIL: begin
        st_d   = ST_OOM;
        res_d  = 16'd0;
        copy_d = 8'd0;
      end
      OP_ALLOC_OK: begin
        st_d   = ST_OK;
        copy_d = (op_q != CMD_REALLOC) ? 8'd0 :
                 (nsz_q > size_q) ? size_q[7:0] : nsz_q[7:0];
      end
      default: begin
        st_d = st_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumClasses; i++) begin
        head_q[i] <= Nil;
      end
      pool_start_q <= 17'd0;
      pool_end_q   <= 17'd0;
      arena_top_q  <= 17'd0;
      heap_total_q <= 17'd0;
    end else begin
      head_q       <= head_d;
      pool_start_q <= pool_start_d;
      pool_end_q   <= pool_end_d;
      arena_top_q  <= arena_top_d;
      heap_total_q <= heap_total_d;
    end
  end

  // Payload and work registers.
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    size_q <= size_d;
    addr_q <= addr_d;
    nsz_q  <= nsz_d;
    cls_q  <= cls_d;
    scan_q <= scan_d;
    sz_q   <= sz_d;
    need_q <= need_d;
    cnt_q  <= cnt_d;
    k_q    <= k_d;
    rem_q  <= rem_d;
    gk_q   <= gk_d;
    res_q  <= res_d;
    st_q   <= st_d;
    copy_q <= copy_d;
  end

  // Link store.
  scfa_ram #(
    .Width(GranW),
    .Depth(NGran)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_addr_o = res_q;
  assign status_o      = st_q;
  assign copy_bytes_o  = copy_q;

endmodule

### rtl/scfa_ctrl.sv
// Controller state machine that sequences the allocator datapath.
`include "size_class_free_list_allocator_unit_defines.svh"
module scfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  scfa_pkg::dp_sts_t sts_i,
  output scfa_pkg::dp_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  import scfa_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (start_i) state_d = S_DECODE;
      S_DECODE: begin
        if (sts_i.dec_alloc) state_d = S_POP;
        else if (sts_i.dec_free) state_d = S_FREE;
        else state_d = S_DONE;
      end
      S_FREE:     state_d = S_DONE;
      S_POP:      state_d = sts_i.head_ok ? S_POP_WB : S_CHUNK;
      S_POP_WB:   state_d = S_ALLOC_OK;
      S_CHUNK: begin
        if (sts_i.left_ge_need) state_d = S_CARVE;
        else if (sts_i.left_ge_sz) state_d = S_DIV;
        else state_d = S_REFILL;
      end
      S_REFILL:   state_d = sts_i.get_fits ? S_CHUNK : S_SCAN;
      S_DIV:      state_d = sts_i.rem_ge_sz ? S_DIV : S_CARVE;
      S_SCAN: begin
        if (sts_i.head_ok) state_d = S_SCAN_WB;
        else if (sts_i.scan_last) state_d = S_DONE;
      end
      S_SCAN_WB:  state_d = S_CHUNK;
      S_CARVE: begin
        if (!sts_i.cnt_gt1 || sts_i.carve_last) state_d = S_ALLOC_OK;
      end
      S_ALLOC_OK: state_d = sts_i.realloc_free ? S_FREE : S_DONE;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.hsel = HS_CLS;
    case (state_q)
      S_IDLE:     if (start_i) cmd_o.op = OP_LOAD;
      S_DECODE:   cmd_o.op = OP_DECODE;
      S_FREE: begin
        cmd_o.op   = OP_PUSH_OLD;
        cmd_o.hsel = HS_FREE;
      end
      S_POP:      if (sts_i.head_ok) cmd_o.op = OP_POP_RD;
      S_POP_WB:   cmd_o.op = OP_POP_WB;
      S_CHUNK: begin
        cmd_o.hsel = HS_LEFT;
        if (sts_i.left_ge_need) cmd_o.op = OP_TAKE_ALL;
        else if (sts_i.left_ge_sz) cmd_o.op = OP_DIV_INIT;
        else if (sts_i.left_nz) cmd_o.op = OP_PUSH_LEFT;
      end
      S_REFILL:   cmd_o.op = sts_i.get_fits ? OP_REFILL : OP_SCAN_INIT;
      S_DIV:      cmd_o.op = sts_i.rem_ge_sz ? OP_DIV_STEP : OP_DIV_END;
      S_SCAN: begin
        cmd_o.hsel = HS_SCAN;
        if (sts_i.head_ok) cmd_o.op = OP_SCAN_RD;
        else if (sts_i.scan_last) cmd_o.op = OP_FAIL;
        else cmd_o.op = OP_SCAN_NEXT;
      end
      S_SCAN_WB: begin
        cmd_o.op   = OP_SCAN_WB;
        cmd_o.hsel = HS_SCAN;
      end
      S_CARVE:    if (sts_i.cnt_gt1) cmd_o.op = OP_CARVE;
      S_ALLOC_OK: cmd_o.op = OP_ALLOC_OK;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

  // The block only goes idle right after presenting a result word.
  `SCFA_ASSERT(a_idle_after_done, $fell(busy_o) |-> $past(state_q == S_DONE), "idle without result")
  // A pop writeback always follows the cycle that issued the link read.
  `SCFA_ASSERT_IMP(a_pop_wb_order, state_q == S_POP_WB, $past(state_q == S_POP), "pop order")
  // Carving never runs past the number of blocks taken from the pool.
  `SCFA_ASSERT_IMP(a_carve_bound, (state_q == S_CARVE) && sts_i.cnt_gt1, sts_i.k_lt_cnt,
                   "carve overrun")

endmodule

### rtl/size_class_free_list_allocator_unit.sv
// Top level of the size class free list allocator.
// Usage: drive cmd_i, size_i, block_addr_i and new_size_i and raise start; the word is
// taken at a rising edge where start is high and busy is low. busy stays high until the
// result word has been shown. The result (result_addr_o, status_o, copy_bytes_o) is valid
// for exactly one cycle while done_o is high; the receiver cannot stall it.
// Flow: a reject, a same-size reallocate or an unused command goes from decode straight
// to the result; a free first pushes the block onto its list; a hit on a free list pops
// the list head through the link store, and a reallocate that also frees the old block
// pushes it after the allocation. A miss carves the pool and links each block after the
// first (up to 19) onto the class list; a pool short of a full refill is divided by
// repeated subtraction for the block count. An arena refill grows the pool; with the arena
// spent, the fallback scan looks at each class (up to 16) from the requested one upward.
// Next word: it can be taken in the idle cycle right after done_o; no new word is taken
// while busy, as the sequencer walks the single-write-port link store one entry per
// cycle.
// Reset: all lists are empty and the pool and arena are empty. The link store has no
// reset; its entries are written before any read.
module size_class_free_list_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] size_i,
  input  logic [15:0] block_addr_i,
  input  logic [15:0] new_size_i,
  output logic        done_o,
  output logic [15:0] result_addr_o,
  output logic [1:0]  status_o,
  output logic [7:0]  copy_bytes_o
);

  import scfa_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer.
  scfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (dp_sts),
    .cmd_o  (dp_cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  // Datapath with the list heads, pool and link store.
  scfa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .cmd_field_i  (cmd_i),
    .size_i       (size_i),
    .block_addr_i (block_addr_i),
    .new_size_i   (new_size_i),
    .sts_o        (dp_sts),
    .result_addr_o(result_addr_o),
    .status_o     (status_o),
    .copy_bytes_o (copy_bytes_o)
  );

endmodule
